// ===== rtl/core/sbmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbmt_pkg;

    localparam int OFF_W   = 40;
    localparam int LEN_W   = 21;
    localparam int ZMASK_W = 16;
    localparam int ADDR_W  = 41;
    localparam int CLEN_W  = 17;
    localparam int ZERO_W  = 16;
    localparam int SIZE_W  = 11;
    localparam int SHIFT_W = 5;
    localparam int BASE_W  = 40;
    localparam int DEV_W   = 27;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd9;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;
    localparam logic [SIZE_W-1:0]  SIZE_RST  = 11'd1024;
    localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd12;

    typedef enum logic [0:0] {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_RD_ZERO = 3'd1,
        ACT_RD_MAP  = 3'd2,
        ACT_WR_MAP  = 3'd3,
        ACT_WR_NEW  = 3'd4,
        ACT_SKIP    = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        REG_SIZE  = 2'd0,
        REG_SHIFT = 2'd1,
        REG_BASE  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_op                op;
        logic [OFF_W-1:0]   byte_offset;
        logic [LEN_W-1:0]   byte_length;
        logic [ZMASK_W-1:0] zero_chunks;
    } t_req;

    typedef struct packed {
        t_action           action;
        logic [ADDR_W-1:0] phys_address;
        logic [CLEN_W-1:0] chunk_length;
        logic [ZERO_W-1:0] lead_zeros;
        logic [ZERO_W-1:0] trail_zeros;
        logic [LEN_W-1:0]  bytes_done;
        logic              truncated;
        logic              last;
    } t_res;

    typedef struct packed {
        logic [SIZE_W-1:0]  size_blocks;
        logic [SHIFT_W-1:0] block_shift;
        logic [BASE_W-1:0]  data_base;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic              sub;
    } t_alu_req;

endpackage

`default_nettype wire

// ===== rtl/core/sbmt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbmt_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire  logic                     i_clk,
    input  wire  logic                     i_we,
    input  wire  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  logic [WIDTH-1:0]         i_wdata,
    input  wire  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic       [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/sbmt_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbmt_regs (
    input  wire  logic                          i_clk,
    input  wire  logic                          i_rst_n,
    input  wire  logic                          i_psel,
    input  wire  logic                          i_penable,
    input  wire  logic                          i_pwrite,
    input  wire  logic [sbmt_pkg::PADDR_W-1:0]  i_paddr,
    input  wire  logic [sbmt_pkg::PDATA_W-1:0]  i_pwdata,
    output logic       [sbmt_pkg::PDATA_W-1:0]  o_prdata,
    output logic                                o_pready,
    output sbmt_pkg::t_cfg                      o_cfg
);
    import sbmt_pkg::*;

    logic [SIZE_W-1:0]  r_size;
    logic [SHIFT_W-1:0] r_shift;
    logic [BASE_W-1:0]  r_base;
    logic               w_wr;
    t_reg_idx           w_idx;

    assign w_idx    = t_reg_idx'(i_paddr[PADDR_W-1:3]);
    assign w_wr     = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SIZE_RST;
            r_shift <= SHIFT_RST;
            r_base  <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SIZE:  r_size  <= i_pwdata[SIZE_W-1:0];
                REG_SHIFT: r_shift <= i_pwdata[SHIFT_W-1:0];
                REG_BASE:  r_base  <= i_pwdata[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SIZE:  o_prdata = PDATA_W'(r_size);
            REG_SHIFT: o_prdata = PDATA_W'(r_shift);
            REG_BASE:  o_prdata = PDATA_W'(r_base);
            default:   o_prdata = '0;
        endcase
    end

    assign o_cfg.size_blocks = r_size;
    assign o_cfg.block_shift = r_shift;
    assign o_cfg.data_base   = r_base;

endmodule

`default_nettype wire

// ===== rtl/core/sbmt_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbmt_alu (
    input  wire  sbmt_pkg::t_alu_req        i_req,
    output logic [sbmt_pkg::ADDR_W-1:0]     o_res,
    output logic                            o_cout
);
    import sbmt_pkg::*;

    logic [ADDR_W:0] w_full;

    // cout is the carry of an add, the borrow of a subtract
    assign w_full = i_req.sub ? ({1'b0, i_req.a} - {1'b0, i_req.b})
                              : ({1'b0, i_req.a} + {1'b0, i_req.b});
    assign o_res  = w_full[ADDR_W-1:0];
    assign o_cout = w_full[ADDR_W];

endmodule

`default_nettype wire

// ===== rtl/core/sbmt_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbmt_seq #(
    parameter int MAX_BLOCKS = 1024,
    parameter int MAX_CHUNKS = 16
) (
    input  wire  logic   i_clk,
    input  wire  logic   i_rst_n,
    input  wire  sbmt_pkg::t_cfg i_cfg,
    input  wire  logic   i_in_valid,
    output logic         o_in_ready,
    input  wire  sbmt_pkg::t_req i_req,
    output logic         o_out_valid,
    input  wire  logic   i_out_ready,
    output sbmt_pkg::t_res o_res
);
    import sbmt_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int NW = $clog2(MAX_BLOCKS + 1);
    localparam int KW = $clog2(MAX_CHUNKS + 1);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_CHK   = 12'b0000_0000_0100,
        S_REM   = 12'b0000_0000_1000,
        S_TRIM  = 12'b0000_0001_0000,
        S_ROOM  = 12'b0000_0010_0000,
        S_SUM   = 12'b0000_0100_0000,
        S_CAP   = 12'b0000_1000_0000,
        S_RD    = 12'b0001_0000_0000,
        S_ADDR  = 12'b0010_0000_0000,
        S_DONE  = 12'b0100_0000_0000,
        S_TRAIL = 12'b1000_0000_0000
    } t_state;

    // control
    t_state             r_state,     n_state;
    logic [AW-1:0]      r_clr,       n_clr;
    logic [NW-1:0]      r_next,      n_next;
    logic               r_out_valid, n_out_valid;
    // payload
    t_op                r_op,    n_op;
    logic [OFF_W-1:0]   r_off,   n_off;
    logic [LEN_W-1:0]   r_len,   n_len;
    logic [ZMASK_W-1:0] r_zmask, n_zmask;
    logic [DEV_W-1:0]   r_tmp,   n_tmp;
    logic [ZERO_W-1:0]  r_inb,   n_inb;
    logic [SIZE_W-1:0]  r_blk,   n_blk;
    logic [CLEN_W-1:0]  r_room,  n_room;
    logic [CLEN_W-1:0]  r_clen,  n_clen;
    logic [LEN_W-1:0]   r_done,  n_done;
    logic               r_trunc, n_trunc;
    logic [KW-1:0]      r_k,     n_k;
    t_action            r_act,   n_act;
    logic [ADDR_W-1:0]  r_addr,  n_addr;
    t_res               r_res,   n_res;

    logic [SIZE_W-1:0]  w_sb;
    logic [SHIFT_W-1:0] w_sh;
    logic [ADDR_W-1:0]  w_dev;
    logic [ADDR_W-1:0]  w_cap;
    logic [CLEN_W-1:0]  w_bs;
    logic [ZERO_W-1:0]  w_inb_mask;

    t_alu_req           w_alu;
    logic [ADDR_W-1:0]  w_alu_res;
    logic               w_alu_cout;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [AW-1:0]      w_wdata;
    logic [AW-1:0]      w_rdata;

    logic               w_mapped;
    logic               w_new;
    logic [AW-1:0]      w_phys;
    logic [ZERO_W-1:0]  w_lead;
    t_action            w_act;
    logic               w_out_free;
    logic               w_last;

    always_comb begin
        w_sb = (32'(i_cfg.size_blocks) > 32'(MAX_BLOCKS)) ? SIZE_W'(MAX_BLOCKS)
                                                          : i_cfg.size_blocks;
        if (i_cfg.block_shift < SHIFT_MIN) begin
            w_sh = SHIFT_MIN;
        end else if (i_cfg.block_shift > SHIFT_MAX) begin
            w_sh = SHIFT_MAX;
        end else begin
            w_sh = i_cfg.block_shift;
        end
    end

    assign w_dev      = ADDR_W'(w_sb) << w_sh;
    assign w_cap      = ADDR_W'(MAX_CHUNKS) << w_sh;
    assign w_bs       = CLEN_W'(1) << w_sh;
    assign w_inb_mask = ~({ZERO_W{1'b1}} << w_sh);

    // chunk decision, valid in S_ADDR once the map word is back
    assign w_mapped = (r_blk == '0) || (w_rdata != '0);

    always_comb begin
        if (r_op == OP_READ) begin
            w_act = w_mapped ? ACT_RD_MAP : ACT_RD_ZERO;
        end else if (w_mapped) begin
            w_act = ACT_WR_MAP;
        end else if (r_zmask[0]) begin
            w_act = ACT_SKIP;
        end else if (r_next >= NW'(MAX_BLOCKS)) begin
            w_act = ACT_NONE;
        end else begin
            w_act = ACT_WR_NEW;
        end
    end

    assign w_new      = (w_act == ACT_WR_NEW);
    assign w_phys     = w_new ? AW'(r_next) : w_rdata;
    assign w_lead     = w_new ? '0 : r_inb;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_last     = (r_act == ACT_NONE) || (r_len == '0)
                        || (r_k == KW'(MAX_CHUNKS - 1));

    always_comb begin
        w_alu = '0;
        unique case (r_state)
            S_CHK: begin
                w_alu.a = ADDR_W'(r_off);
                w_alu.b = w_dev;
                w_alu.sub = 1'b1;
            end
            S_REM: begin
                w_alu.a = w_dev;
                w_alu.b = ADDR_W'(r_off);
                w_alu.sub = 1'b1;
            end
            S_TRIM: begin
                w_alu.a = ADDR_W'(r_tmp);
                w_alu.b = ADDR_W'(r_len);
                w_alu.sub = 1'b1;
            end
            S_ROOM: begin
                w_alu.a = ADDR_W'(w_bs);
                w_alu.b = ADDR_W'(r_inb);
                w_alu.sub = 1'b1;
            end
            S_SUM: begin
                w_alu.a = ADDR_W'(r_inb);
                w_alu.b = ADDR_W'(r_len);
            end
            S_CAP: begin
                w_alu.a = w_cap;
                w_alu.b = ADDR_W'(r_tmp);
                w_alu.sub = 1'b1;
            end
            S_RD: begin
                w_alu.a = ADDR_W'(r_len);
                w_alu.b = ADDR_W'(r_room);
                w_alu.sub = 1'b1;
            end
            S_ADDR: begin
                w_alu.a = ADDR_W'(i_cfg.data_base);
                w_alu.b = (ADDR_W'(w_phys) << w_sh) | ADDR_W'(w_lead);
            end
            S_DONE: begin
                w_alu.a = ADDR_W'(r_done);
                w_alu.b = ADDR_W'(r_clen);
            end
            S_TRAIL: begin
                w_alu.a = ADDR_W'(r_room);
                w_alu.b = ADDR_W'(r_clen);
                w_alu.sub = 1'b1;
            end
            default: ;
        endcase
    end

    sbmt_alu u_alu (
        .i_req  (w_alu),
        .o_res  (w_alu_res),
        .o_cout (w_alu_cout)
    );

    assign w_we    = (r_state == S_CLEAR) || ((r_state == S_ADDR) && w_new);
    assign w_waddr = (r_state == S_CLEAR) ? r_clr : AW'(r_blk);
    assign w_wdata = (r_state == S_CLEAR) ? '0 : w_phys;

    sbmt_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_BLOCKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (AW'(r_blk)),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_next      = r_next;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_off       = r_off;
        n_len       = r_len;
        n_zmask     = r_zmask;
        n_tmp       = r_tmp;
        n_inb       = r_inb;
        n_blk       = r_blk;
        n_room      = r_room;
        n_clen      = r_clen;
        n_done      = r_done;
        n_trunc     = r_trunc;
        n_k         = r_k;
        n_act       = r_act;
        n_addr      = r_addr;
        n_res       = r_res;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(MAX_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_req.op;
                    n_off   = i_req.byte_offset;
                    n_len   = i_req.byte_length;
                    n_zmask = i_req.zero_chunks;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                // no borrow: offset at or past the device end
                if (!w_alu_cout || (r_len == '0)) begin
                    if (w_out_free) begin
                        n_res        = '0;
                        n_res.action = ACT_NONE;
                        n_res.last   = 1'b1;
                        n_out_valid  = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_state = S_REM;
                end
            end
            S_REM: begin
                n_tmp   = w_alu_res[DEV_W-1:0];
                n_inb   = r_off[ZERO_W-1:0] & w_inb_mask;
                n_blk   = SIZE_W'(r_off >> w_sh);
                n_state = S_TRIM;
            end
            S_TRIM: begin
                if (w_alu_cout) begin
                    n_len = LEN_W'(r_tmp);
                end
                n_state = S_ROOM;
            end
            S_ROOM: begin
                n_room  = w_alu_res[CLEN_W-1:0];
                n_state = S_SUM;
            end
            S_SUM: begin
                n_tmp   = w_alu_res[DEV_W-1:0];
                n_state = S_CAP;
            end
            S_CAP: begin
                n_trunc = w_alu_cout;
                n_done  = '0;
                n_k     = '0;
                n_state = S_RD;
            end
            S_RD: begin
                if (w_alu_cout) begin
                    n_clen = CLEN_W'(r_len);
                    n_len  = '0;
                end else begin
                    n_clen = r_room;
                    n_len  = w_alu_res[LEN_W-1:0];
                end
                n_state = S_ADDR;
            end
            S_ADDR: begin
                n_act  = w_act;
                n_addr = ((w_act == ACT_RD_MAP) || (w_act == ACT_WR_MAP) || w_new)
                         ? w_alu_res : '0;
                if (w_new) begin
                    n_next = r_next + 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (r_act != ACT_NONE) begin
                    n_done = w_alu_res[LEN_W-1:0];
                end
                n_state = S_TRAIL;
            end
            S_TRAIL: begin
                if (w_out_free) begin
                    n_res.action       = r_act;
                    n_res.phys_address = r_addr;
                    n_res.chunk_length = r_clen;
                    n_res.lead_zeros   = (r_act == ACT_WR_NEW) ? r_inb : '0;
                    n_res.trail_zeros  = (r_act == ACT_WR_NEW) ? w_alu_res[ZERO_W-1:0]
                                                               : '0;
                    n_res.bytes_done   = r_done;
                    n_res.truncated    = r_trunc;
                    n_res.last         = w_last;
                    n_out_valid        = 1'b1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_room  = w_bs;
                        n_inb   = '0;
                        n_blk   = r_blk + 1'b1;
                        n_k     = r_k + 1'b1;
                        n_zmask = r_zmask >> 1;
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_next      <= NW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_next      <= n_next;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_off   <= n_off;
        r_len   <= n_len;
        r_zmask <= n_zmask;
        r_tmp   <= n_tmp;
        r_inb   <= n_inb;
        r_blk   <= n_blk;
        r_room  <= n_room;
        r_clen  <= n_clen;
        r_done  <= n_done;
        r_trunc <= n_trunc;
        r_k     <= n_k;
        r_act   <= n_act;
        r_addr  <= n_addr;
        r_res   <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/sparse_block_map_translator.sv =====
// Sequence: a request runs six setup steps, then read, address, count and trail
//   steps per chunk, all through one shared 41-bit add/subtract unit. Each result
//   is registered in the trail step, which waits while the last result is untaken;
//   an out-of-range or empty request gives its single result from the check step.
//   A new request is taken only in idle, once the previous one is finished.
// Reset: synchronous, active low; the block map is then cleared entry by
//   entry, during which no request is taken.
`timescale 1ns / 1ps
`default_nettype none

module sparse_block_map_translator #(
    parameter int MAX_BLOCKS = 1024,
    parameter int MAX_CHUNKS = 16
) (
    input  wire  logic                          i_clk,
    input  wire  logic                          i_rst_n,
    input  wire  logic                          psel,
    input  wire  logic                          penable,
    input  wire  logic                          pwrite,
    input  wire  logic [sbmt_pkg::PADDR_W-1:0]  paddr,
    input  wire  logic [sbmt_pkg::PDATA_W-1:0]  pwdata,
    output logic       [sbmt_pkg::PDATA_W-1:0]  prdata,
    output logic                                pready,
    input  wire  logic                          i_in_valid,
    output logic                                o_in_ready,
    input  wire  sbmt_pkg::t_req                i_req,
    output logic                                o_out_valid,
    input  wire  logic                          i_out_ready,
    output sbmt_pkg::t_res                      o_res
);
    import sbmt_pkg::*;

    t_cfg w_cfg;

    sbmt_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    sbmt_seq #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req       (i_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ===== sim/tb_sparse_block_map_translator.sv =====
`timescale 1ns / 1ps

module tb_sparse_block_map_translator;
    import sbmt_pkg::*;

    localparam int MAP_DEPTH      = 1024;
    localparam int CHUNK_LIMIT    = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_STALL     = 400;
    localparam int SETTLE_CYCLES  = 16;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_ready;
    t_req               i_req;
    logic               o_out_valid;
    logic               i_out_ready;
    t_res               o_res;

    // translation model state
    logic [9:0]         block_map_model [MAP_DEPTH];
    logic [10:0]        next_free_blk;
    logic [SIZE_W-1:0]  size_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [BASE_W-1:0]  base_reg;
    t_res               expected_chunks[$];

    int mismatches     = 0;
    int requests_sent  = 0;
    int chunks_checked = 0;
    int action_seen[6] = '{default: 0};
    int quiet_cycles   = 0;
    bit idle_on        = 1'b1;
    bit stall_toggle   = 1'b0;

    sparse_block_map_translator #(
        .MAX_BLOCKS (MAP_DEPTH),
        .MAX_CHUNKS (CHUNK_LIMIT)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req       (i_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (o_res)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int unsigned eff_size();
        return (size_reg > MAP_DEPTH) ? MAP_DEPTH : size_reg;
    endfunction

    function automatic int unsigned eff_shift();
        return (shift_reg < SHIFT_MIN) ? SHIFT_MIN :
               (shift_reg > SHIFT_MAX) ? SHIFT_MAX : shift_reg;
    endfunction

    // Splits one request into chunk results and updates the map copy
    task automatic translate_request(input t_req r);
        logic [63:0] bsz;
        logic [63:0] devb;
        logic [63:0] len;
        logic [63:0] inb;
        logic [63:0] blk;
        logic [63:0] clen;
        logic [63:0] done;
        int unsigned sh;
        int unsigned k;
        logic [9:0]  phys;
        bit          mapped;
        bit          trunc;
        bit          stop;
        t_res        res;
        sh   = eff_shift();
        bsz  = 64'd1 << sh;
        devb = 64'(eff_size()) << sh;
        len  = 64'(r.byte_length);
        if (64'(r.byte_offset) >= devb || len == 0) begin
            res        = '0;
            res.action = ACT_NONE;
            res.last   = 1'b1;
            expected_chunks.push_back(res);
            return;
        end
        if (64'(r.byte_offset) + len > devb) len = devb - 64'(r.byte_offset);
        inb   = 64'(r.byte_offset) & (bsz - 1);
        blk   = 64'(r.byte_offset) >> sh;
        trunc = ((inb + len + bsz - 1) >> sh) > CHUNK_LIMIT;
        done  = 0;
        k     = 0;
        stop  = 1'b0;
        while (k < CHUNK_LIMIT && len > 0 && !stop) begin
            clen   = (bsz - inb < len) ? bsz - inb : len;
            phys   = block_map_model[blk];
            mapped = (blk == 0) || (phys != 0);
            res              = '0;
            res.chunk_length = CLEN_W'(clen);
            res.truncated    = trunc;
            res.bytes_done   = LEN_W'(done + clen);
            if (r.op == OP_READ) begin
                res.action = mapped ? ACT_RD_MAP : ACT_RD_ZERO;
                if (mapped)
                    res.phys_address = ADDR_W'(64'(base_reg) + (64'(phys) << sh) + inb);
            end else if (mapped) begin
                res.action       = ACT_WR_MAP;
                res.phys_address = ADDR_W'(64'(base_reg) + (64'(phys) << sh) + inb);
            end else if (r.zero_chunks[k]) begin
                res.action = ACT_SKIP;
            end else if (next_free_blk >= MAP_DEPTH) begin
                // no space left: report and stop the request here
                res.action     = ACT_NONE;
                res.bytes_done = LEN_W'(done);
                res.last       = 1'b1;
                stop           = 1'b1;
            end else begin
                res.action           = ACT_WR_NEW;
                res.phys_address     = ADDR_W'(64'(base_reg) + (64'(next_free_blk) << sh));
                res.lead_zeros       = ZERO_W'(inb);
                res.trail_zeros      = ZERO_W'(bsz - inb - clen);
                block_map_model[blk] = next_free_blk[9:0];
                next_free_blk        = next_free_blk + 11'd1;
            end
            expected_chunks.push_back(res);
            done = done + clen;
            len  = len - clen;
            inb  = 0;
            blk  = blk + 1;
            k    = k + 1;
        end
        res      = expected_chunks.pop_back();
        res.last = 1'b1;
        expected_chunks.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_chunks.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected, expected none, actual %p",
                         $time, o_res);
            end else begin
                want = expected_chunks.pop_front();
                check_field("action",       64'(want.action),       64'(o_res.action));
                check_field("phys_address", 64'(want.phys_address), 64'(o_res.phys_address));
                check_field("chunk_length", 64'(want.chunk_length), 64'(o_res.chunk_length));
                check_field("lead_zeros",   64'(want.lead_zeros),   64'(o_res.lead_zeros));
                check_field("trail_zeros",  64'(want.trail_zeros),  64'(o_res.trail_zeros));
                check_field("bytes_done",   64'(want.bytes_done),   64'(o_res.bytes_done));
                check_field("truncated",    64'(want.truncated),    64'(o_res.truncated));
                check_field("last",         64'(want.last),         64'(o_res.last));
                chunks_checked++;
                if (want.action <= ACT_SKIP) action_seen[int'(want.action)]++;
            end
        end
    end

    // result side: random hold-offs plus one long stall on request
    initial begin
        int  gap;
        bit  stall_seen;
        stall_seen = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_toggle != stall_seen) begin
                stall_seen = stall_toggle;
                i_out_ready <= 1'b0;
                repeat (LONG_STALL - 1) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 14);
                i_out_ready <= 1'b0;
                repeat (gap - 1) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SIZE:  size_reg  = value[SIZE_W-1:0];
            REG_SHIFT: shift_reg = value[SHIFT_W-1:0];
            REG_BASE:  base_reg  = value[BASE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [SIZE_W-1:0] size, input logic [SHIFT_W-1:0] shift,
                              input logic [BASE_W-1:0] base);
        write_reg(REG_SIZE, 64'(size));
        write_reg(REG_SHIFT, 64'(shift));
        write_reg(REG_BASE, 64'(base));
    endtask

    task automatic send_item(input t_req r, input bit more);
        int gap;
        i_in_valid <= 1'b1;
        i_req      <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        translate_request(r);
        requests_sent++;
        if (!more) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_batch(input t_req batch[$]);
        foreach (batch[i]) send_item(batch[i], i + 1 < batch.size());
    endtask

    task automatic wait_idle();
        while (expected_chunks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_req make_req(input t_op op, input logic [39:0] off,
                                      input logic [20:0] len, input logic [15:0] zc);
        t_req r;
        r.op          = op;
        r.byte_offset = off;
        r.byte_length = len;
        r.zero_chunks = zc;
        return r;
    endfunction

    function automatic t_req random_request();
        t_req        r;
        int unsigned sh;
        int unsigned bsz;
        int unsigned devb;
        int unsigned hot;
        int unsigned pick;
        int unsigned back;
        sh   = eff_shift();
        bsz  = 1 << sh;
        devb = eff_size() << sh;
        hot  = ((eff_size() < 48) ? eff_size() : 48) * bsz;
        r.op = t_op'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (devb == 0 || pick < 8) begin
            r.byte_offset = OFF_W'({$urandom, $urandom});
        end else if (pick < 50) begin
            // small hot region so that blocks are revisited
            r.byte_offset = OFF_W'($urandom_range(0, hot - 1));
        end else if (pick < 62) begin
            back = $urandom_range(1, 2 * bsz);
            r.byte_offset = OFF_W'((devb > back) ? devb - back : 0);
        end else begin
            r.byte_offset = OFF_W'($urandom_range(0, devb - 1));
        end
        pick = $urandom_range(0, 99);
        if (pick < 8)       r.byte_length = LEN_W'($urandom_range(0, 21'h1F_FFFF));
        else if (pick < 18) r.byte_length = LEN_W'($urandom_range(bsz, 18 * bsz));
        else if (pick < 22) r.byte_length = '0;
        else                r.byte_length = LEN_W'($urandom_range(1, 3 * bsz));
        case ($urandom_range(0, 2))
            0:       r.zero_chunks = '0;
            1:       r.zero_chunks = ZMASK_W'($urandom);
            default: r.zero_chunks = ZMASK_W'($urandom & $urandom);
        endcase
        return r;
    endfunction

    task automatic test_directed();
        t_req batch[$];
        logic [39:0] devb;
        set_config(11'd1024, 5'd12, 40'h12_3456_7000);
        devb = 40'd1024 << 12;
        batch.push_back(make_req(OP_READ,  40'd20580, 21'd200, 16'h0000));
        batch.push_back(make_req(OP_WRITE, 40'd10, 21'd50, 16'hFFFF));
        batch.push_back(make_req(OP_WRITE, 40'd20480, 21'd4096, 16'h0001));
        batch.push_back(make_req(OP_WRITE, 40'd24480, 21'd4296, 16'h0002));
        batch.push_back(make_req(OP_READ,  40'd24480, 21'd4296, 16'h0000));
        batch.push_back(make_req(OP_WRITE, 40'd24480, 21'd4296, 16'h0000));
        batch.push_back(make_req(OP_WRITE, 40'd4096, 21'd0, 16'h0000));
        batch.push_back(make_req(OP_READ,  devb, 21'd16, 16'h0000));
        batch.push_back(make_req(OP_WRITE, 40'hFF_FFFF_FFFF, 21'd16, 16'h0000));
        batch.push_back(make_req(OP_WRITE, 40'd3, 21'h1F_FFFF, 16'hAAAA));
        batch.push_back(make_req(OP_READ,  40'd3, 21'd1048576, 16'h0000));
        batch.push_back(make_req(OP_READ,  devb - 100, 21'd5000, 16'h0000));
        batch.push_back(make_req(OP_WRITE, devb - 4096, 21'd4096, 16'h0000));
        send_batch(batch);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        t_req batch[$];
        set_config(11'd0, 5'd12, 40'd0);
        batch.push_back(make_req(OP_READ,  40'd0, 21'd1, 16'h0000));
        batch.push_back(make_req(OP_WRITE, 40'd4096, 21'd100, 16'h0000));
        send_batch(batch);
        wait_idle();

        // oversize device, shift above range, base at its top
        batch = {};
        set_config(11'd2047, 5'd31, 40'hFF_FFFF_FFFF);
        batch.push_back(make_req(OP_WRITE, (40'd1023 << 16) + 40'd65535, 21'd1, 16'h0000));
        batch.push_back(make_req(OP_WRITE, 40'd9 * 65536 + 40'd65535, 21'd2, 16'h0000));
        batch.push_back(make_req(OP_WRITE, 40'd11 * 65536, 21'd65536, 16'h0000));
        batch.push_back(make_req(OP_READ,  40'd0, 21'd131077, 16'h0000));
        batch.push_back(make_req(OP_READ,  40'd9 * 65536, 21'd196608, 16'h0000));
        send_batch(batch);
        wait_idle();

        // shift below range on a tiny device
        batch = {};
        set_config(11'd5, 5'd0, 40'd0);
        batch.push_back(make_req(OP_READ,  40'd2559, 21'd10, 16'h0000));
        batch.push_back(make_req(OP_WRITE, 40'd512, 21'd1536, 16'h0000));
        batch.push_back(make_req(OP_WRITE, 40'd2560, 21'd1, 16'h0000));
        send_batch(batch);
        wait_idle();
    endtask

    task automatic test_random();
        t_req batch[$];
        logic [SIZE_W-1:0]  size;
        logic [SHIFT_W-1:0] shift;
        for (int phase = 0; phase < 4; phase++) begin
            idle_on = (phase != 2);
            case ($urandom_range(0, 3))
                0:       size = 11'd1024;
                1:       size = SIZE_W'($urandom_range(1, 1024));
                2:       size = SIZE_W'($urandom_range(1025, 2047));
                default: size = SIZE_W'($urandom_range(1, 64));
            endcase
            shift = ($urandom_range(0, 3) == 0) ? SHIFT_W'($urandom_range(0, 31))
                                                : SHIFT_W'($urandom_range(9, 16));
            set_config(size, shift, BASE_W'({$urandom, $urandom}));
            batch = {};
            for (int i = 0; i < 4; i++) batch.push_back(random_request());
            send_batch(batch);
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        t_req batch[$];
        idle_on = 1'b0;
        set_config(11'd1024, 5'd9, BASE_W'({$urandom, $urandom}));
        for (int i = 0; i < 8; i++)
            batch.push_back(make_req(t_op'($urandom_range(0, 1)),
                                     OFF_W'($urandom_range(0, 32767)),
                                     LEN_W'($urandom_range(1, 1024)),
                                     ZMASK_W'($urandom)));
        stall_toggle <= ~stall_toggle;
        send_batch(batch);
        wait_idle();
    endtask

    // fills every logical block, running the free pointer to its end
    task automatic test_map_sweep();
        t_req batch[$];
        idle_on = 1'b0;
        set_config(11'd1024, 5'd9, 40'd0);
        for (int b = 0; b < MAP_DEPTH; b += 16)
            batch.push_back(make_req(OP_WRITE, 40'(b) * 512, 21'd8192, 16'h0000));
        batch.push_back(make_req(OP_READ, 40'd0, 21'd8192, 16'h0000));
        batch.push_back(make_req(OP_READ, 40'd1000 * 512, 21'd8192, 16'h0000));
        send_batch(batch);
        wait_idle();
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_in_valid <= 1'b0;
        i_req      <= '0;
        foreach (block_map_model[i]) block_map_model[i] = '0;
        next_free_blk = 11'd1;
        size_reg      = SIZE_RST;
        shift_reg     = SHIFT_RST;
        base_reg      = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);

        test_directed();
        test_register_extremes();
        test_random();
        test_backpressure();
        test_map_sweep();

        $display("Sent %0d requests over directed, register-extreme, random, stall and sweep runs;",
                 requests_sent);
        $display("checked %0d chunks: range %0d, rd-zero %0d, rd-map %0d, wr-map %0d, new %0d, skip %0d",
                 chunks_checked, action_seen[0], action_seen[1], action_seen[2],
                 action_seen[3], action_seen[4], action_seen[5]);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
